/* src/ist_pkg.sv */
// Shared types and constants for the interrupt span tracker.
// Used by every module of the block; depends on nothing.
package ist_pkg;

  localparam int VECTOR_COUNT_DEF = 10;
  localparam int CPU_COUNT_DEF    = 64;
  localparam int QUEUE_DEPTH      = 2;

  localparam int CPU_W       = 6;
  localparam int VEC_IN_W    = 8;
  localparam int VEC_OUT_W   = 4;
  localparam int TS_W        = 64;
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 208;

  localparam logic FUNC_ENTRY = 1'b0;
  localparam logic FUNC_EXIT  = 1'b1;

  // Decoded event as it travels from front to back (slot index rides beside it).
  typedef struct packed {
    logic [TS_W-1:0]      timestamp;
    logic [VEC_OUT_W-1:0] vec;
    logic [CPU_W-1:0]     cpu;
    logic                 func;
  } ist_event_t;

  // One table word per (processor, vector).
  typedef struct packed {
    logic [TS_W-1:0] unresolved;
    logic [TS_W-1:0] observed;
    logic [TS_W-1:0] start;
  } ist_entry_t;

  // Result item, first field in the highest bits (out_cpu in the lowest).
  typedef struct packed {
    logic [TS_W-1:0]      unresolved_total;
    logic [TS_W-1:0]      observed_total;
    logic [TS_W-1:0]      event_duration;
    logic [VEC_OUT_W-1:0] out_vector;
    logic [CPU_W-1:0]     out_cpu;
  } ist_result_t;

  localparam int RESULT_W = $bits(ist_result_t);

  function automatic int slot_width(input int slots);
    return (slots > 1) ? $clog2(slots) : 1;
  endfunction

endpackage

/* src/ist_front.sv */
// Front end: takes input items, drops out-of-range ones, computes the table slot.
// Depends on ist_pkg.
module ist_front
  import ist_pkg::*;
#(
  parameter int VECTOR_COUNT = VECTOR_COUNT_DEF,
  parameter int CPU_COUNT    = CPU_COUNT_DEF,
  parameter int SLOT_W       = slot_width(VECTOR_COUNT * CPU_COUNT)
) (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  input  logic                  clearing,
  input  logic                  q_full,
  output logic                  q_push,
  output ist_event_t            q_event,
  output logic [SLOT_W-1:0]     q_slot
);

  logic [CPU_W-1:0]    cpu;
  logic [VEC_IN_W-1:0] vec;
  logic [TS_W-1:0]     ts;
  logic                in_range;

  assign cpu = in_tdata[CPU_W-1:0];
  assign vec = in_tdata[CPU_W +: VEC_IN_W];
  assign ts  = in_tdata[CPU_W+VEC_IN_W +: TS_W];

  assign in_range  = (32'(vec) < VECTOR_COUNT) && (32'(cpu) < CPU_COUNT);
  assign in_tready = !q_full && !clearing;
  assign q_push    = in_tvalid && in_tready && in_range;

  assign q_event.timestamp = ts;
  assign q_event.vec       = vec[VEC_OUT_W-1:0];
  assign q_event.cpu       = cpu;
  assign q_event.func      = in_tuser[0];
  assign q_slot            = SLOT_W'(32'(cpu) * VECTOR_COUNT + 32'(vec));

endmodule

/* src/ist_queue.sv */
// Short FIFO between front and back.
// Depends on ist_pkg for its default depth.
module ist_queue
  import ist_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/ist_back.sv */
// Back end: span table memory, read-modify-write per item, result register.
// Depends on ist_pkg.
module ist_back
  import ist_pkg::*;
#(
  parameter int SLOTS  = VECTOR_COUNT_DEF * CPU_COUNT_DEF,
  parameter int SLOT_W = slot_width(VECTOR_COUNT_DEF * CPU_COUNT_DEF)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  ist_event_t             q_event,
  input  logic [SLOT_W-1:0]      q_slot,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  ist_entry_t mem [SLOTS];

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SLOT_W-1:0] slot_r;
  ist_event_t        ev_r;
  ist_entry_t        rd_word_r;
  logic              out_valid_r, out_valid_nxt;
  ist_result_t       out_data_r;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  ist_entry_t        mem_wdata;
  ist_entry_t        upd;
  logic              pending;
  logic              emit;
  logic [TS_W-1:0]   dur;
  ist_result_t       result;

  assign clearing   = (state_r == ST_CLEAR);
  assign q_pop      = (state_r == ST_IDLE) && q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), out_data_r};

  always_comb begin
    upd     = rd_word_r;
    emit    = 1'b0;
    pending = |rd_word_r.start;
    dur     = ev_r.timestamp - rd_word_r.start;
    if (ev_r.func == FUNC_ENTRY) begin
      if (pending) begin
        upd.unresolved = rd_word_r.unresolved + 1'b1;
        emit           = 1'b1;
      end
      upd.start = ev_r.timestamp;
    end else if (!pending) begin
      upd.unresolved = rd_word_r.unresolved + 1'b1;
    end else begin
      upd.observed = rd_word_r.observed + 1'b1;
      upd.start    = '0;
      emit         = 1'b1;
    end
    result.unresolved_total = upd.unresolved;
    result.observed_total   = upd.observed;
    result.event_duration   = dur;
    result.out_vector       = ev_r.vec;
    result.out_cpu          = ev_r.cpu;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = slot_r;
    mem_wdata     = upd;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        mem_we    = 1'b1;
        state_nxt = ST_IDLE;
        if (emit) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ev_r   <= q_event;
      slot_r <= q_slot;
    end
    if (state_r == ST_UPDATE && emit) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_word_r <= mem[q_slot];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

endmodule

/* src/interrupt_span_tracker_core.sv */
// Channel  | Dir | Ports                         | Payload
// in_      | in  | in_tvalid/in_tready           | in_tdata, in_tuser
// out_     | out | out_tvalid/out_tready         | out_tdata
//
// Each item takes a registered read of the span table, then a write back of the
// updated entry (single table port); the next item waits for that write back.
// After reset the table is cleared, one entry a cycle, all CPU_COUNT*VECTOR_COUNT
// entries (640 by default); in_tready stays low during that pass.
// A 2-entry queue lets the input keep flowing while a result waits on out_tready.
// Depends on ist_pkg, ist_front, ist_queue, ist_back.
module interrupt_span_tracker_core
  import ist_pkg::*;
#(
  parameter int VECTOR_COUNT = VECTOR_COUNT_DEF,
  parameter int CPU_COUNT    = CPU_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // cpu_id[5:0], vector[13:6], timestamp[77:14], pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // func[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // out_cpu[5:0], out_vector[9:6],
                                             // event_duration[73:10],
                                             // observed_total[137:74],
                                             // unresolved_total[201:138], pad
);

  localparam int SLOTS  = VECTOR_COUNT * CPU_COUNT;
  localparam int SLOT_W = slot_width(SLOTS);
  localparam int QW     = $bits(ist_event_t) + SLOT_W;

  logic              clearing;
  logic              q_full;
  logic              q_push;
  ist_event_t        push_event;
  logic [SLOT_W-1:0] push_slot;
  logic              q_pop;
  logic              q_valid;
  logic [QW-1:0]     q_head;
  ist_event_t        head_event;
  logic [SLOT_W-1:0] head_slot;

  assign head_event = q_head[QW-1:SLOT_W];
  assign head_slot  = q_head[SLOT_W-1:0];

  ist_front #(
    .VECTOR_COUNT (VECTOR_COUNT),
    .CPU_COUNT    (CPU_COUNT),
    .SLOT_W       (SLOT_W)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_event   (push_event),
    .q_slot    (push_slot)
  );

  ist_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_event, push_slot}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_head)
  );

  ist_back #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_event    (head_event),
    .q_slot     (head_slot),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* src/ist_checker.sv */
// Port-level checks for interrupt_span_tracker_core, bound to the top level.
// Depends on ist_pkg.
module ist_checker
  import ist_pkg::*;
#(
  parameter int VECTOR_COUNT = VECTOR_COUNT_DEF,
  parameter int CPU_COUNT    = CPU_COUNT_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // table clear holds off input right after reset
  a_clear_blocks_input: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input accepted during table clear");

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_vector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (VECTOR_COUNT >= 16) || (32'(out_tdata[9:6]) < VECTOR_COUNT))
    else $error("result vector out of range");

  a_cpu_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[5:0]) < CPU_COUNT))
    else $error("result processor out of range");

endmodule

bind interrupt_span_tracker_core ist_checker #(
  .VECTOR_COUNT (VECTOR_COUNT),
  .CPU_COUNT    (CPU_COUNT)
) u_ist_checker (.*);

/* verif/interrupt_span_tracker_core_test.sv */
// Self-checking bench for interrupt_span_tracker_core: directed event table, then random
// entry/exit traffic with idling and back-pressure, checked against an in-bench span model.
// Depends on ist_pkg and interrupt_span_tracker_core.
module interrupt_span_tracker_core_test;
  import ist_pkg::*;

  localparam int VEC_COUNT   = VECTOR_COUNT_DEF;
  localparam int CORE_COUNT  = CPU_COUNT_DEF;
  localparam int RAND_ITEMS  = 750;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int PLAN_ROWS   = 18;
  localparam logic [63:0] TS_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic        func;
    logic [5:0]  cpu;
    logic [7:0]  vec;
    logic [63:0] ts;
    bit          typed;
    bit          has;
    logic [63:0] dur;
    logic [63:0] obs;
    logic [63:0] unres;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [IN_TUSER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // span model state
  logic [63:0] span_start [CORE_COUNT][VEC_COUNT];
  logic [63:0] span_done  [CORE_COUNT][VEC_COUNT];
  logic [63:0] span_stray [CORE_COUNT][VEC_COUNT];

  ist_result_t spans_due[$];
  plan_row_t   plan [PLAN_ROWS];

  int  cycles;
  int  errors;
  int  shown;
  int  hold_left;
  bit  hold_req;

  interrupt_span_tracker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** interrupt_span_tracker_core: FAILED **");
      $finish;
    end
  end

  task automatic flag(input string msg);
    errors++;
    if (shown < 10) begin
      shown++;
      $display("[%0d] %s", cycles, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want)
      flag($sformatf("%s mismatch: expected %h, got %h", name, want, got));
  endtask

  // Applies one event to the span model; has says whether a result follows.
  task automatic track_span(input logic func, input logic [5:0] cpu, input logic [7:0] vec,
                            input logic [63:0] ts, output bit has, output ist_result_t span);
    logic [63:0] start;
    has  = 1'b0;
    span = '0;
    if (vec >= VEC_COUNT || cpu >= CORE_COUNT) return;
    start = span_start[cpu][vec];
    if (func == FUNC_ENTRY) begin
      if (start != 0) begin
        span_stray[cpu][vec] += 1;
        has = 1'b1;
      end
      span_start[cpu][vec] = ts;
    end else if (start == 0) begin
      span_stray[cpu][vec] += 1;
    end else begin
      span_done[cpu][vec] += 1;
      span_start[cpu][vec] = '0;
      has = 1'b1;
    end
    span.out_cpu          = cpu;
    span.out_vector       = vec[3:0];
    span.event_duration   = ts - start;
    span.observed_total   = span_done[cpu][vec];
    span.unresolved_total = span_stray[cpu][vec];
  endtask

  task automatic offer_event(input logic func, input logic [5:0] cpu, input logic [7:0] vec,
                             input logic [63:0] ts, output bit has, output ist_result_t span);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {2'b00, ts, vec, cpu};
    do @(posedge clk); while (!in_tready);
    track_span(func, cpu, vec, ts, has, span);
  endtask

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic sender_gap(input int len);
    if (len > 0) begin
      in_tvalid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic drain_spans();
    in_tvalid <= 1'b0;
    while (spans_due.size() != 0) @(posedge clk);
  endtask

  // result side: check, then decide ready for the next cycle
  initial begin
    ist_result_t got;
    ist_result_t want;
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = ist_result_t'(out_tdata[RESULT_W-1:0]);
        if (spans_due.size() == 0) begin
          flag($sformatf("unexpected item: cpu %0d vec %0d", got.out_cpu, got.out_vector));
        end else begin
          want = spans_due.pop_front();
          check_field("out_cpu", 64'(want.out_cpu), 64'(got.out_cpu));
          check_field("out_vector", 64'(want.out_vector), 64'(got.out_vector));
          check_field("event_duration", want.event_duration, got.event_duration);
          check_field("observed_total", want.observed_total, got.observed_total);
          check_field("unresolved_total", want.unresolved_total, got.unresolved_total);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if ((cycles / 500) % 4 == 2) begin
        out_tready <= 1'b1;
      end else begin
        stall = pick_idle();
        out_tready <= (stall == 0);
      end
    end
  end

  initial begin
    bit          has;
    ist_result_t span;
    ist_result_t typed_span;
    int          counted;
    int          r;
    logic        func;
    logic [5:0]  cpu;
    logic [7:0]  vec;
    logic [63:0] ts;
    logic [63:0] clock_ns;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cycles    = 0;
    errors    = 0;
    shown     = 0;
    hold_left = 0;
    hold_req  = 1'b0;
    for (int c = 0; c < CORE_COUNT; c++)
      for (int v = 0; v < VEC_COUNT; v++) begin
        span_start[c][v] = '0;
        span_done[c][v]  = '0;
        span_stray[c][v] = '0;
      end

    plan = '{
      '{FUNC_EXIT,  6'd0,  8'd0,   64'd100, 1, 0, 64'd0, 64'd0, 64'd0},
      '{FUNC_ENTRY, 6'd0,  8'd0,   64'd100, 1, 0, 64'd0, 64'd0, 64'd0},
      '{FUNC_EXIT,  6'd0,  8'd0,   64'd350, 1, 1, 64'd250, 64'd1, 64'd1},
      '{FUNC_ENTRY, 6'd63, 8'd9,   TS_MAX,  1, 0, 64'd0, 64'd0, 64'd0},
      '{FUNC_ENTRY, 6'd63, 8'd9,   64'd5,   1, 1, 64'd6, 64'd0, 64'd1},
      '{FUNC_EXIT,  6'd63, 8'd9,   64'd4,   1, 1, TS_MAX, 64'd1, 64'd1},
      // vectors past the table are dropped
      '{FUNC_ENTRY, 6'd1,  8'd10,  64'd7,   1, 0, 64'd0, 64'd0, 64'd0},
      '{FUNC_EXIT,  6'd1,  8'd255, 64'd7,   1, 0, 64'd0, 64'd0, 64'd0},
      '{FUNC_ENTRY, 6'd1,  8'd170, TS_MAX,  1, 0, 64'd0, 64'd0, 64'd0},
      // entry at time zero reads back as nothing pending
      '{FUNC_ENTRY, 6'd2,  8'd3,   64'd0,   1, 0, 64'd0, 64'd0, 64'd0},
      '{FUNC_EXIT,  6'd2,  8'd3,   64'd50,  1, 0, 64'd0, 64'd0, 64'd0},
      '{FUNC_ENTRY, 6'd2,  8'd3,   64'd0,   1, 0, 64'd0, 64'd0, 64'd0},
      '{FUNC_ENTRY, 6'd2,  8'd3,   64'd9,   1, 0, 64'd0, 64'd0, 64'd0},
      '{FUNC_EXIT,  6'd2,  8'd3,   64'd20,  1, 1, 64'd11, 64'd1, 64'd1},
      '{FUNC_ENTRY, 6'd42, 8'd5,   64'h8000_0000_0000_0000, 0, 0, '0, '0, '0},
      '{FUNC_EXIT,  6'd42, 8'd5,   64'h8000_0000_0000_0001, 0, 0, '0, '0, '0},
      '{FUNC_ENTRY, 6'd21, 8'd6,   64'h0123_4567_89AB_CDEF, 0, 0, '0, '0, '0},
      '{FUNC_ENTRY, 6'd21, 8'd6,   64'hFEDC_BA98_7654_3210, 0, 0, '0, '0, '0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      offer_event(plan[i].func, plan[i].cpu, plan[i].vec, plan[i].ts, has, span);
      if (plan[i].typed) begin
        if (plan[i].has) begin
          typed_span.out_cpu          = plan[i].cpu;
          typed_span.out_vector       = plan[i].vec[3:0];
          typed_span.event_duration   = plan[i].dur;
          typed_span.observed_total   = plan[i].obs;
          typed_span.unresolved_total = plan[i].unres;
          spans_due.push_back(typed_span);
        end
      end else if (has) begin
        spans_due.push_back(span);
      end
      sender_gap(pick_idle());
    end
    drain_spans();

    counted  = 0;
    clock_ns = 64'd1000;
    while (counted < RAND_ITEMS) begin
      if (counted == 250 && hold_left == 0) hold_req = 1'b1;
      if (counted == 500) begin
        drain_spans();
        counted++;
      end
      cpu = ($urandom_range(0, 99) < 60) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
      vec = 8'($urandom_range(0, VEC_COUNT - 1));
      r = $urandom_range(0, 99);
      if (r < 70)
        func = (span_start[cpu][vec] != 0) ? FUNC_EXIT : FUNC_ENTRY;
      else if (r < 85)
        func = FUNC_ENTRY;
      else if (r < 95)
        func = FUNC_EXIT;
      else begin
        func = 1'($urandom_range(0, 1));
        vec  = 8'($urandom_range(VEC_COUNT, 255));
      end
      r = $urandom_range(0, 99);
      if (r < 80) begin
        clock_ns += 64'($urandom_range(1, 5000));
        ts = clock_ns;
      end else if (r < 95) begin
        ts = {$urandom, $urandom};
      end else begin
        ts = '0;
      end
      offer_event(func, cpu, vec, ts, has, span);
      if (has) spans_due.push_back(span);
      if (vec < VEC_COUNT) counted++;
      if (hold_req || hold_left > 0 || (counted / 100) % 4 == 1)
        sender_gap(0);
      else
        sender_gap(pick_idle());
    end

    drain_spans();
    repeat (20) @(posedge clk);
    if (errors == 0 && spans_due.size() == 0)
      $display("** interrupt_span_tracker_core: PASSED **");
    else
      $display("** interrupt_span_tracker_core: FAILED **");
    $finish;
  end

endmodule

/* interrupt_span_tracker_core.f */
src/ist_pkg.sv
src/ist_front.sv
src/ist_queue.sv
src/ist_back.sv
src/interrupt_span_tracker_core.sv
src/ist_checker.sv
verif/interrupt_span_tracker_core_test.sv
